@@ hw/rtl/thde_pkg.sv @@
// ----------------------------------------------------------------------------
// thde_pkg
// Shared types, character codes and helper functions of the terminal
// half-block delta encoder.
// ----------------------------------------------------------------------------
package thde_pkg;

    // Largest zero-based coordinate; larger values are saturated to it.
    localparam int unsigned COORD_MAX = 1023;
    localparam logic [9:0]  COORD_LIM = 10'(COORD_MAX);

    // Depth of the command queue between front and back; a power of two.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // Line event codes.
    localparam logic [1:0] EV_CONT  = 2'd0;
    localparam logic [1:0] EV_FRAME = 2'd1;
    localparam logic [1:0] EV_LINE  = 2'd2;

    // Characters of the stream.
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;  // '['
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_THREE = 8'h33;  // '3'
    localparam logic [7:0] CH_FOUR  = 8'h34;  // '4'
    localparam logic [7:0] CH_FIVE  = 8'h35;  // '5'
    localparam logic [7:0] CH_EIGHT = 8'h38;  // '8'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_H     = 8'h48;  // 'H'
    localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_G0    = 8'hE2;  // upper half block, UTF-8
    localparam logic [7:0] CH_G1    = 8'h96;
    localparam logic [7:0] CH_G2    = 8'h80;

    // Segments of one cell's output, in the order in which they are sent.
    typedef enum logic [2:0] {
        SEG_RESET,
        SEG_MOVE_A,
        SEG_MOVE_B,
        SEG_BG,
        SEG_FG,
        SEG_TAIL
    } t_seg;

    localparam int unsigned SEG_NUM = 6;

    typedef logic [SEG_NUM-1:0] t_flags;

    // One classified cell, as handed from the front to the back.
    typedef struct packed {
        t_flags      flags;
        logic        glyph;    // half block rather than a space
        logic [10:0] row1;     // one-based row
        logic [10:0] col1;     // one-based column
        logic [1:0]  row_pw;   // power of ten of the leading digit
        logic [1:0]  col_pw;
        logic [7:0]  bg_col;
        logic [7:0]  fg_col;
        logic [1:0]  bg_pw;
        logic [1:0]  fg_pw;
    } t_cmd;

    // Steps of the byte sequencer.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ESC,
        ST_LBR,
        ST_ZERO,
        ST_RM,
        ST_ROW,
        ST_MSEMI,
        ST_COL,
        ST_H,
        ST_SEL,
        ST_EIGHT,
        ST_SEMI_A,
        ST_FIVE,
        ST_SEMI_B,
        ST_COLOR,
        ST_CM,
        ST_SPACE,
        ST_G0,
        ST_G1,
        ST_G2
    } t_step;

    function automatic logic [13:0] f_pow10(input logic [1:0] pw);
        logic [13:0] p;
        unique case (pw)
            2'd0:    p = 14'd1;
            2'd1:    p = 14'd10;
            2'd2:    p = 14'd100;
            default: p = 14'd1000;
        endcase
        return p;
    endfunction

    // Power of ten of the leading digit, so that no leading zero is sent.
    function automatic logic [1:0] f_start_pow(input logic [10:0] v);
        logic [1:0] pw;
        if (v >= 11'd1000) begin
            pw = 2'd3;
        end else if (v >= 11'd100) begin
            pw = 2'd2;
        end else if (v >= 11'd10) begin
            pw = 2'd1;
        end else begin
            pw = 2'd0;
        end
        return pw;
    endfunction

endpackage

@@ hw/rtl/thde_if.sv @@
// ----------------------------------------------------------------------------
// thde_if
// Valid/ready channels of the encoder: cells in, stream bytes out.
// ----------------------------------------------------------------------------
interface thde_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] line_event;
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] new_upper;
    logic [7:0] new_lower;
    logic [7:0] old_upper;
    logic [7:0] old_lower;

    modport source (
        output valid, line_event, row, col, new_upper, new_lower, old_upper, old_lower,
        input  ready
    );
    modport sink (
        input  valid, line_event, row, col, new_upper, new_lower, old_upper, old_lower,
        output ready
    );
endinterface

interface thde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (
        output valid, out_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_byte,
        output ready
    );
endinterface

@@ hw/rtl/terminal_halfblock_delta_encoder_core.sv @@
// ----------------------------------------------------------------------------
// terminal_halfblock_delta_encoder_core
// Turns half-block character cells into the ANSI byte stream that updates a
// terminal, sending only what changed.
// ----------------------------------------------------------------------------
// A cell is accepted in every cycle while the two-entry command queue between
// the classifying front end and the byte sequencer has room; an unchanged cell
// without a frame or line mark only updates the state and takes no queue
// entry. The sequencer sends one word per cycle while the sink is ready. A
// cell produces no bytes when it is unchanged and has no mark, about ten to
// sixteen for a typical changed one and at most 53, with consecutive cells
// sent back to back. The first byte of a cell that enters an empty block
// passes through the queue, the command and step registers of the sequencer
// and the output register. Decimal numbers are sent one digit per cycle
// while the sink is ready, by a compare ladder on the remainder.
// ----------------------------------------------------------------------------
module terminal_halfblock_delta_encoder_core
    import thde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    thde_in_if.sink    i_in,
    thde_out_if.source o_out
);

    logic q_push, q_full, q_valid, q_pop;
    t_cmd q_wdata, q_rdata;

    thde_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (q_push),
        .o_cmd   (q_wdata),
        .i_full  (q_full)
    );

    thde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (q_pop)
    );

    thde_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_rdata),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

@@ hw/rtl/thde_front.sv @@
// ----------------------------------------------------------------------------
// thde_front
// Accepts cells, tracks the colours already sent and the pending cursor
// jump, and turns each cell into a command for the byte sequencer.
// ----------------------------------------------------------------------------
module thde_front
    import thde_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    thde_in_if.sink       i_in,
    output logic          o_push,
    output t_cmd          o_cmd,
    input  logic          i_full
);

    logic [7:0] r_fg_sent, n_fg_sent;
    logic       r_fg_known, n_fg_known;
    logic [7:0] r_bg_sent, n_bg_sent;
    logic       r_bg_known, n_bg_known;
    logic       r_jump, n_jump;

    logic       accept;
    logic       frame, line;
    logic       unchanged;
    logic       fg_known_eff, bg_known_eff, jump_eff;
    logic [9:0] row_c, col_c;
    t_cmd       cmd;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        frame     = (i_in.line_event == EV_FRAME);
        line      = (i_in.line_event == EV_LINE);
        unchanged = (i_in.new_upper == i_in.old_upper) && (i_in.new_lower == i_in.old_lower);

        // A frame start clears everything; a line start forgets the colours only.
        bg_known_eff = r_bg_known && !frame && !line;
        fg_known_eff = r_fg_known && !frame && !line;
        jump_eff     = r_jump && !frame;

        row_c = (i_in.row > COORD_LIM) ? COORD_LIM : i_in.row;
        col_c = (i_in.col > COORD_LIM) ? COORD_LIM : i_in.col;

        cmd        = '0;
        cmd.row1   = {1'b0, row_c} + 11'd1;
        cmd.col1   = {1'b0, col_c} + 11'd1;
        cmd.row_pw = f_start_pow(cmd.row1);
        cmd.col_pw = f_start_pow(cmd.col1);
        cmd.bg_col = i_in.new_lower;
        cmd.fg_col = i_in.new_upper;
        cmd.bg_pw  = f_start_pow({3'b0, i_in.new_lower});
        cmd.fg_pw  = f_start_pow({3'b0, i_in.new_upper});
        cmd.glyph  = (i_in.new_upper != i_in.new_lower);

        cmd.flags[SEG_RESET]  = line;
        cmd.flags[SEG_MOVE_A] = frame || line;

        n_fg_sent  = frame ? 8'd0 : r_fg_sent;
        n_bg_sent  = frame ? 8'd0 : r_bg_sent;
        n_fg_known = fg_known_eff;
        n_bg_known = bg_known_eff;
        n_jump     = 1'b1;

        if (!unchanged) begin
            n_jump                = 1'b0;
            cmd.flags[SEG_MOVE_B] = jump_eff;
            cmd.flags[SEG_BG]     = !bg_known_eff || (r_bg_sent != i_in.new_lower);
            cmd.flags[SEG_TAIL]   = 1'b1;
            n_bg_sent             = i_in.new_lower;
            n_bg_known            = 1'b1;
            if (cmd.glyph) begin
                cmd.flags[SEG_FG] = !fg_known_eff || (r_fg_sent != i_in.new_upper);
                n_fg_sent         = i_in.new_upper;
                n_fg_known        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_sent  <= 8'd0;
            r_fg_known <= 1'b0;
            r_bg_sent  <= 8'd0;
            r_bg_known <= 1'b0;
            r_jump     <= 1'b0;
        end else if (accept) begin
            r_fg_sent  <= n_fg_sent;
            r_fg_known <= n_fg_known;
            r_bg_sent  <= n_bg_sent;
            r_bg_known <= n_bg_known;
            r_jump     <= n_jump;
        end
    end

    // Cells that send nothing only update the state.
    assign o_push = accept && (cmd.flags != '0);
    assign o_cmd  = cmd;

endmodule

@@ hw/rtl/thde_queue.sv @@
// ----------------------------------------------------------------------------
// thde_queue
// Short command queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module thde_queue
    import thde_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_count;
    t_cmd            r_mem [Q_DEPTH];

    logic do_push, do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/thde_back.sv @@
// ----------------------------------------------------------------------------
// thde_back
// Byte sequencer: walks the segments of one command; while the sink is ready it
// sends one word, decimal numbers one digit, per cycle via an output register.
// ----------------------------------------------------------------------------
module thde_back
    import thde_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    thde_out_if.source    o_out
);

    t_step       r_step, n_step;
    t_seg        r_seg, n_seg;
    t_flags      r_pend, n_pend;
    t_cmd        r_cmd, n_cmd;
    logic [10:0] r_rem, n_rem;
    logic [1:0]  r_pw, n_pw;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_olast, n_olast;

    logic        adv;
    logic        seg_end;
    logic        num_step;
    logic [3:0]  digit;
    logic [13:0] sub;
    logic [13:0] thr;
    logic [7:0]  byte_now;
    logic [7:0]  color;
    logic [1:0]  color_pw;
    t_seg        next_seg;
    t_seg        load_seg;

    function automatic t_seg f_first(input t_flags f);
        t_seg s;
        s = SEG_TAIL;
        for (int i = SEG_NUM - 1; i >= 0; i--) begin
            if (f[i]) begin
                s = t_seg'(3'(i));
            end
        end
        return s;
    endfunction

    function automatic t_step f_start(input t_seg s, input logic glyph);
        t_step st;
        if (s == SEG_TAIL) begin
            st = glyph ? ST_G0 : ST_SPACE;
        end else begin
            st = ST_ESC;
        end
        return st;
    endfunction

    assign adv      = !r_ovalid || o_out.ready;
    assign num_step = (r_step == ST_ROW) || (r_step == ST_COL) || (r_step == ST_COLOR);
    assign next_seg = f_first(r_pend);
    assign load_seg = f_first(i_cmd.flags);

    // Leading digit of the remainder at the current power of ten.
    always_comb begin
        digit = 4'd0;
        sub   = 14'd0;
        for (int k = 1; k <= 9; k++) begin
            thr = 14'(f_pow10(r_pw) * 14'(k));
            if ({3'b0, r_rem} >= thr) begin
                digit = 4'(k);
                sub   = thr;
            end
        end
    end

    always_comb begin
        color    = (r_seg == SEG_BG) ? r_cmd.bg_col : r_cmd.fg_col;
        color_pw = (r_seg == SEG_BG) ? r_cmd.bg_pw : r_cmd.fg_pw;

        unique case (r_step)
            ST_ESC:                       byte_now = CH_ESC;
            ST_LBR:                       byte_now = CH_LBR;
            ST_ZERO:                      byte_now = CH_ZERO;
            ST_RM, ST_CM:                 byte_now = CH_M;
            ST_ROW, ST_COL, ST_COLOR:     byte_now = CH_ZERO + {4'd0, digit};
            ST_MSEMI, ST_SEMI_A, ST_SEMI_B: byte_now = CH_SEMI;
            ST_H:                         byte_now = CH_H;
            ST_SEL:                       byte_now = (r_seg == SEG_BG) ? CH_FOUR : CH_THREE;
            ST_EIGHT:                     byte_now = CH_EIGHT;
            ST_FIVE:                      byte_now = CH_FIVE;
            ST_SPACE:                     byte_now = CH_SPACE;
            ST_G0:                        byte_now = CH_G0;
            ST_G1:                        byte_now = CH_G1;
            ST_G2:                        byte_now = CH_G2;
            default:                      byte_now = CH_SPACE;
        endcase

        seg_end = (r_step == ST_RM) || (r_step == ST_H) || (r_step == ST_CM) ||
                  (r_step == ST_SPACE) || (r_step == ST_G2);
    end

    always_comb begin
        n_step   = r_step;
        n_seg    = r_seg;
        n_pend   = r_pend;
        n_cmd    = r_cmd;
        n_rem    = r_rem;
        n_pw     = r_pw;
        n_ovalid = r_ovalid && !o_out.ready;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        o_pop    = 1'b0;

        if (r_step == ST_IDLE) begin
            if (i_valid) begin
                o_pop            = 1'b1;
                n_cmd            = i_cmd;
                n_seg            = load_seg;
                n_pend           = i_cmd.flags;
                n_pend[load_seg] = 1'b0;
                n_step           = f_start(load_seg, i_cmd.glyph);
            end
        end else if (adv) begin
            n_ovalid = 1'b1;
            n_obyte  = byte_now;
            n_olast  = seg_end && (r_pend == '0);

            unique case (r_step)
                ST_ESC:    n_step = ST_LBR;
                ST_LBR: begin
                    unique case (r_seg)
                        SEG_RESET: n_step = ST_ZERO;
                        SEG_MOVE_A, SEG_MOVE_B: begin
                            n_step = ST_ROW;
                            n_rem  = r_cmd.row1;
                            n_pw   = r_cmd.row_pw;
                        end
                        default:   n_step = ST_SEL;
                    endcase
                end
                ST_ZERO:   n_step = ST_RM;
                ST_ROW: begin
                    n_rem = 11'({3'b0, r_rem} - sub);
                    n_pw  = r_pw - 2'd1;
                    if (r_pw == 2'd0) begin
                        n_step = ST_MSEMI;
                    end
                end
                ST_MSEMI: begin
                    n_step = ST_COL;
                    n_rem  = r_cmd.col1;
                    n_pw   = r_cmd.col_pw;
                end
                ST_COL: begin
                    n_rem = 11'({3'b0, r_rem} - sub);
                    n_pw  = r_pw - 2'd1;
                    if (r_pw == 2'd0) begin
                        n_step = ST_H;
                    end
                end
                ST_SEL:    n_step = ST_EIGHT;
                ST_EIGHT:  n_step = ST_SEMI_A;
                ST_SEMI_A: n_step = ST_FIVE;
                ST_FIVE:   n_step = ST_SEMI_B;
                ST_SEMI_B: begin
                    n_step = ST_COLOR;
                    n_rem  = {3'b0, color};
                    n_pw   = color_pw;
                end
                ST_COLOR: begin
                    n_rem = 11'({3'b0, r_rem} - sub);
                    n_pw  = r_pw - 2'd1;
                    if (r_pw == 2'd0) begin
                        n_step = ST_CM;
                    end
                end
                ST_G0:     n_step = ST_G1;
                ST_G1:     n_step = ST_G2;
                default:   n_step = r_step;
            endcase

            // At the end of a segment go on to the next one, or straight to the
            // next command so that cells follow each other without a gap.
            if (seg_end) begin
                if (r_pend != '0) begin
                    n_seg            = next_seg;
                    n_pend           = r_pend;
                    n_pend[next_seg] = 1'b0;
                    n_step           = f_start(next_seg, r_cmd.glyph);
                end else if (i_valid) begin
                    o_pop            = 1'b1;
                    n_cmd            = i_cmd;
                    n_seg            = load_seg;
                    n_pend           = i_cmd.flags;
                    n_pend[load_seg] = 1'b0;
                    n_step           = f_start(load_seg, i_cmd.glyph);
                end else begin
                    n_step = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_IDLE;
            r_seg    <= SEG_RESET;
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_seg    <= n_seg;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_rem   <= n_rem;
        r_pw    <= n_pw;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.out_byte  = r_obyte;
    assign o_out.last_byte = r_olast;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_IDLE) |-> (r_pend == '0))
        else $error("segments pending while the sequencer is idle");

    a_digit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        num_step |-> ({3'b0, r_rem} < 14'(f_pow10(r_pw) * 14'd10)))
        else $error("decimal remainder exceeds the current power of ten");

    a_last_is_final_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |->
        ((r_obyte == CH_H) || (r_obyte == CH_M) || (r_obyte == CH_SPACE) ||
         (r_obyte == CH_G2)))
        else $error("last word of a cell is not a closing character");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the half-block delta encoder. Character cells go in
// on the input channel, and every stream word that comes out is compared with
// the bytes predicted for the cells accepted so far. A short directed sequence
// covers the marks and the number widths. Random frames of small tiles follow,
// with noise cells mixed in. Both sides of the block stall at random.
// ----------------------------------------------------------------------------
module tb;
    import thde_pkg::*;

    localparam logic [1:0]  EV_UNUSED      = 2'd3;
    localparam int unsigned CELL_TARGET    = 420;
    localparam int unsigned WATCHDOG_LIMIT = 400;
    localparam int unsigned TAIL_CYCLES    = 24;

    typedef struct packed {
        logic [1:0] line_event;
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] new_upper;
        logic [7:0] new_lower;
        logic [7:0] old_upper;
        logic [7:0] old_lower;
    } t_cell;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    // Predicts the byte stream of each accepted cell and checks the words sent.
    class halfblock_scoreboard;
        t_stream_byte expected_bytes[$];
        logic [7:0]   fg_sent;
        logic [7:0]   bg_sent;
        logic         fg_known;
        logic         bg_known;
        logic         jump_pending;
        int unsigned  errors;
        int unsigned  cells;
        int unsigned  frame_marks;
        int unsigned  line_marks;
        int unsigned  unchanged_cells;
        int unsigned  words;

        function new();
            clear_state();
            errors          = 0;
            cells           = 0;
            frame_marks     = 0;
            line_marks      = 0;
            unchanged_cells = 0;
            words           = 0;
        endfunction

        function void clear_state();
            fg_sent      = '0;
            bg_sent      = '0;
            fg_known     = 1'b0;
            bg_known     = 1'b0;
            jump_pending = 1'b0;
        endfunction

        function void push_char(logic [7:0] ch);
            t_stream_byte b;
            b.data = ch;
            b.last = 1'b0;
            expected_bytes.push_back(b);
        endfunction

        function void push_decimal(int unsigned v);
            int unsigned p;
            p = 1;
            while (v / p >= 10) begin
                p = p * 10;
            end
            while (p > 0) begin
                push_char(8'(CH_ZERO + (v / p) % 10));
                p = p / 10;
            end
        endfunction

        function void push_move(logic [9:0] r, logic [9:0] c);
            int unsigned rr;
            int unsigned cc;
            rr = (r > COORD_LIM) ? COORD_MAX : int'(r);
            cc = (c > COORD_LIM) ? COORD_MAX : int'(c);
            push_char(CH_ESC);
            push_char(CH_LBR);
            push_decimal(rr + 1);
            push_char(CH_SEMI);
            push_decimal(cc + 1);
            push_char(CH_H);
        endfunction

        function void push_colour(logic [7:0] sel, logic [7:0] colour);
            push_char(CH_ESC);
            push_char(CH_LBR);
            push_char(sel);
            push_char(CH_EIGHT);
            push_char(CH_SEMI);
            push_char(CH_FIVE);
            push_char(CH_SEMI);
            push_decimal(int'(colour));
            push_char(CH_M);
        endfunction

        function void note_cell(t_cell c);
            int unsigned queued;
            queued = expected_bytes.size();
            cells++;
            if (c.line_event == EV_FRAME) begin
                frame_marks++;
                clear_state();
                push_move(c.row, c.col);
            end else if (c.line_event == EV_LINE) begin
                line_marks++;
                fg_known = 1'b0;
                bg_known = 1'b0;
                push_char(CH_ESC);
                push_char(CH_LBR);
                push_char(CH_ZERO);
                push_char(CH_M);
                push_move(c.row, c.col);
            end

            if (c.new_upper == c.old_upper && c.new_lower == c.old_lower) begin
                unchanged_cells++;
                jump_pending = 1'b1;
            end else begin
                if (jump_pending) begin
                    push_move(c.row, c.col);
                    jump_pending = 1'b0;
                end
                if (!bg_known || bg_sent != c.new_lower) begin
                    push_colour(CH_FOUR, c.new_lower);
                    bg_sent  = c.new_lower;
                    bg_known = 1'b1;
                end
                if (c.new_upper == c.new_lower) begin
                    push_char(CH_SPACE);
                end else begin
                    if (!fg_known || fg_sent != c.new_upper) begin
                        push_colour(CH_THREE, c.new_upper);
                        fg_sent  = c.new_upper;
                        fg_known = 1'b1;
                    end
                    push_char(CH_G0);
                    push_char(CH_G1);
                    push_char(CH_G2);
                end
            end

            if (expected_bytes.size() > queued) begin
                expected_bytes[expected_bytes.size() - 1].last = 1'b1;
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] ERROR: %s", $realtime, what);
        endtask

        task check_byte(logic [7:0] data, logic last);
            t_stream_byte want;
            words++;
            if (expected_bytes.size() == 0) begin
                report($sformatf("word %0d (%02h, last %0b) sent with none expected",
                                 words, data, last));
            end else begin
                want = expected_bytes.pop_front();
                if (data !== want.data) begin
                    report($sformatf("word %0d: out_byte %02h, expected %02h",
                                     words, data, want.data));
                end
                if (last !== want.last) begin
                    report($sformatf("word %0d: last_byte %0b, expected %0b",
                                     words, last, want.last));
                end
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    thde_in_if  cell_ch ();
    thde_out_if byte_ch ();

    terminal_halfblock_delta_encoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cell_ch),
        .o_out   (byte_ch)
    );

    halfblock_scoreboard board;
    bit                  steady_flow = 1'b0;
    int unsigned         cells_sent  = 0;
    int unsigned         frames_run  = 0;
    int unsigned         quiet_cycles = 0;
    logic [7:0]          palette [4];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_cell cell_of(logic [1:0] ev, logic [9:0] r, logic [9:0] c,
                                      logic [7:0] nu, logic [7:0] nl,
                                      logic [7:0] ou, logic [7:0] ol);
        t_cell item;
        item.line_event = ev;
        item.row        = r;
        item.col        = c;
        item.new_upper  = nu;
        item.new_lower  = nl;
        item.old_upper  = ou;
        item.old_lower  = ol;
        return item;
    endfunction

    function automatic logic [7:0] pick_colour();
        if ($urandom_range(0, 9) < 7) begin
            return palette[$urandom_range(0, 3)];
        end
        return 8'($urandom);
    endfunction

    task automatic send_cell(t_cell c);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_ch.valid      <= 1'b1;
        cell_ch.line_event <= c.line_event;
        cell_ch.row        <= c.row;
        cell_ch.col        <= c.col;
        cell_ch.new_upper  <= c.new_upper;
        cell_ch.new_lower  <= c.new_lower;
        cell_ch.old_upper  <= c.old_upper;
        cell_ch.old_lower  <= c.old_lower;
        do @(posedge i_clk); while (!cell_ch.ready);
        board.note_cell(c);
        cells_sent++;
    endtask

    // Holds the input back until every predicted word has come out.
    task automatic drain();
        cell_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic directed_cells();
        send_cell(cell_of(EV_FRAME,     0,    0, 8'h00, 8'hFF, 8'h01, 8'hFF));
        send_cell(cell_of(EV_CONT,      0,    1, 8'h00, 8'hFF, 8'hFF, 8'h00));
        send_cell(cell_of(EV_CONT,      0,    2, 8'h12, 8'h12, 8'h00, 8'h00));
        send_cell(cell_of(EV_CONT,      0,    3, 8'h12, 8'h12, 8'h12, 8'h12));
        send_cell(cell_of(EV_CONT,      0,    4, 8'h09, 8'h0A, 8'h0A, 8'h09));
        send_cell(cell_of(EV_LINE,      9,    9, 8'h63, 8'h64, 8'h00, 8'h00));
        send_cell(cell_of(EV_CONT,      9,   98, 8'h63, 8'h64, 8'h63, 8'h64));
        // A jump left pending across a line mark still sends its own move.
        send_cell(cell_of(EV_LINE,     98,   99, 8'h64, 8'h63, 8'h00, 8'h00));
        send_cell(cell_of(EV_LINE,     99,  998, 8'h05, 8'h05, 8'h05, 8'h05));
        send_cell(cell_of(EV_CONT,    998,  999, 8'h05, 8'h05, 8'h06, 8'h05));
        send_cell(cell_of(EV_FRAME,  1023, 1023, 8'h11, 8'h11, 8'h11, 8'h11));
        send_cell(cell_of(EV_UNUSED, 1023,    0, 8'h80, 8'h7F, 8'h00, 8'h00));
        send_cell(cell_of(EV_UNUSED,    0, 1023, 8'h80, 8'h7F, 8'h80, 8'h7F));
        // Longest word run of the sequence: line mark, pending move and both colours.
        send_cell(cell_of(EV_LINE,   1023, 1023, 8'hFF, 8'h00, 8'hFF, 8'h01));
        send_cell(cell_of(EV_FRAME,   512,  256, 8'hAA, 8'h55, 8'h55, 8'hAA));
        send_cell(cell_of(EV_CONT,    341,  682, 8'h55, 8'hAA, 8'h00, 8'h00));
        send_cell(cell_of(EV_CONT,    341,  683, 8'h55, 8'hAA, 8'h55, 8'h00));
        send_cell(cell_of(EV_CONT,    341,  684, 8'h56, 8'hAA, 8'h55, 8'hAA));
        send_cell(cell_of(EV_LINE,      0,    0, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_cell(cell_of(EV_FRAME,     0,    0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_cell(cell_of(EV_CONT,      0,    1, 8'h00, 8'h00, 8'h07, 8'h00));
    endtask

    // One frame of a small tile: a frame mark, line marks at most row starts, and
    // content mostly from a small palette so colours repeat; noise cells mixed in.
    task automatic run_frame();
        int unsigned width;
        int unsigned height;
        logic [9:0]  base_r;
        logic [9:0]  base_c;
        t_cell       c;
        width  = $urandom_range(1, 8);
        height = $urandom_range(1, 3);
        base_r = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 30));
        base_c = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 30));
        for (int k = 0; k < 4; k++) begin
            palette[k] = 8'($urandom);
        end
        steady_flow = ($urandom_range(0, 3) == 0);
        frames_run++;
        if (frames_run == 12) begin
            drain();
        end
        for (int unsigned y = 0; y < height; y++) begin
            for (int unsigned x = 0; x < width; x++) begin
                if ($urandom_range(0, 9) == 0) begin
                    c = cell_of(2'($urandom), 10'($urandom), 10'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom), 8'($urandom));
                    if ($urandom_range(0, 1) == 0) begin
                        c.old_upper = c.new_upper;
                        c.old_lower = c.new_lower;
                    end
                end else begin
                    if (x == 0 && y == 0) begin
                        c.line_event = EV_FRAME;
                    end else if (x == 0 && $urandom_range(0, 9) != 0) begin
                        c.line_event = EV_LINE;
                    end else begin
                        c.line_event = EV_CONT;
                    end
                    c.row       = 10'(base_r + y);
                    c.col       = 10'(base_c + x);
                    c.new_upper = pick_colour();
                    c.new_lower = ($urandom_range(0, 3) == 0) ? c.new_upper : pick_colour();
                    if ($urandom_range(0, 9) < 3) begin
                        c.old_upper = c.new_upper;
                        c.old_lower = c.new_lower;
                    end else begin
                        c.old_upper = ($urandom_range(0, 1) == 0) ? c.new_upper
                                                                   : pick_colour();
                        c.old_lower = ($urandom_range(0, 1) == 0) ? c.new_lower
                                                                   : pick_colour();
                    end
                end
                send_cell(c);
            end
        end
    endtask

    initial begin
        board = new();
        i_rst_n            <= 1'b0;
        cell_ch.valid      <= 1'b0;
        cell_ch.line_event <= EV_CONT;
        cell_ch.row        <= '0;
        cell_ch.col        <= '0;
        cell_ch.new_upper  <= '0;
        cell_ch.new_lower  <= '0;
        cell_ch.old_upper  <= '0;
        cell_ch.old_lower  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_cells();
        drain();
        while (cells_sent < CELL_TARGET) begin
            run_frame();
        end

        cell_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d cells, %0d random frames among them: %0d frame marks,",
                 board.cells, frames_run, board.frame_marks);
        $display("%0d line marks, %0d unchanged; checked %0d stream words, %0d mismatches.",
                 board.line_marks, board.unchanged_cells, board.words, board.errors);
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Output side: a random stall before each word, none in steady stretches.
    initial begin
        int unsigned stall;
        byte_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                byte_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            byte_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!byte_ch.valid);
            board.check_byte(byte_ch.out_byte, byte_ch.last_byte);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cell_ch.valid && cell_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles, %0d words still expected.",
                     quiet_cycles, board.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
